>>> src/multichannel_adc_window_sum_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multichannel window sum core.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_ADC_WINDOW_SUM_CORE_DEFINES_SVH
`define MULTICHANNEL_ADC_WINDOW_SUM_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define MAWSUM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mawsum assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define MAWSUM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mawsum assertion failed");

`else

`define MAWSUM_ASSERT(lbl, clk, rst, prop)
`define MAWSUM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/mawsum_pkg.sv
// ---------------------------------------------------------------------------
// mawsum_pkg
// Shared constants and types of the multichannel window sum core.
// ---------------------------------------------------------------------------
package mawsum_pkg;

   localparam int CHANNELS_PER_BANK = 8;
   localparam int WINDOW_DEPTH      = 32;
   localparam int BANK_COUNT        = 2;

   localparam int SLOT_COUNT = BANK_COUNT * CHANNELS_PER_BANK;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int HEAD_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int ADDR_W     = SLOT_W + HEAD_W;
   localparam int RING_DEPTH = 2 ** ADDR_W;

   // Converter word layout
   localparam int WORD_W     = 32;
   localparam int CHAN_W     = 3;
   localparam int CHAN_LSB   = 24;
   localparam int SAMPLE_W   = 10;
   localparam int SAMPLE_LSB = 6;
   localparam int SUM_W      = 15;

   // Window length fields
   localparam int LEN_W     = 6;
   localparam int CNT_W     = LEN_W + 1;
   localparam int LEN_REG_W = 48;
   localparam int ENABLE_W  = 16;

   // Register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE    = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_LEN_BANK0 = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_LEN_BANK1 = CSR_ADDR_W'(2);

   // Result stream
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (CHAN_W + SAMPLE_W + SUM_W + 1);

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } ram_wr_type;

   // Item leaving the head stage
   typedef struct packed {
      logic                valid;
      logic                bank;
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample;
      logic                upd;
      logic [ADDR_W-1:0]   addr;
   } issue_type;

   // Item held in the sum stage
   typedef struct packed {
      logic                bank;
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample;
      logic                upd;
      logic [ADDR_W-1:0]   addr;
      logic                fwd;
      logic [SAMPLE_W-1:0] fwd_data;
   } stage_type;

endpackage

>>> src/mawsum_ram.sv
// ---------------------------------------------------------------------------
// mawsum_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mawsum_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/mawsum_index.sv
// ---------------------------------------------------------------------------
// mawsum_index
// Input register, word decode, per-slot ring heads and ring read issue.
// ---------------------------------------------------------------------------
`include "multichannel_adc_window_sum_core_defines.svh"

module mawsum_index (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_bank,
   input  logic [mawsum_pkg::WORD_W-1:0]       req_word,
   input  logic                                clearing,
   input  logic [mawsum_pkg::SLOT_COUNT-1:0]   enable_mask,
   input  logic [mawsum_pkg::LEN_REG_W-1:0]    len_bank0,
   input  logic [mawsum_pkg::LEN_REG_W-1:0]    len_bank1,
   input  logic                                s2_ready,
   output mawsum_pkg::ram_rd_type              rd_req,
   output mawsum_pkg::issue_type               issue
);

   import mawsum_pkg::*;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_bank_ff;
   logic [CHAN_W-1:0]   s1_chan_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [HEAD_W-1:0]   head_ff [SLOT_COUNT];

   logic                s1_go;
   logic                accept;
   logic                exists;
   logic                upd;
   logic [SLOT_W-1:0]   slot;
   logic [LEN_REG_W-1:0] len_reg;
   logic [LEN_W-1:0]    len_field;
   logic [CNT_W-1:0]    len_eff;
   logic [CNT_W-1:0]    nh_inc;
   logic [CNT_W-1:0]    nh_wide;
   logic [HEAD_W-1:0]   nh;

   always_comb begin
      s1_go       = s1_valid_ff && s2_ready;
      req_ready   = !clearing && (!s1_valid_ff || s2_ready);
      accept      = req_valid && req_ready;
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

      exists = (int'(s1_bank_ff) < BANK_COUNT) && (int'(s1_chan_ff) < CHANNELS_PER_BANK);
      slot   = SLOT_W'(int'(s1_bank_ff) * CHANNELS_PER_BANK + int'(s1_chan_ff));
      upd    = exists && enable_mask[slot];

      len_reg   = s1_bank_ff ? len_bank1 : len_bank0;
      len_field = len_reg[int'(s1_chan_ff) * LEN_W +: LEN_W];
      // zero length acts as one, oversize saturates to the ring depth
      if (len_field == '0) begin
         len_eff = CNT_W'(1);
      end else if (int'(len_field) > WINDOW_DEPTH) begin
         len_eff = CNT_W'(WINDOW_DEPTH);
      end else begin
         len_eff = CNT_W'(len_field);
      end

      nh_inc  = CNT_W'(head_ff[slot]) + CNT_W'(1);
      nh_wide = (nh_inc >= len_eff) ? '0 : nh_inc;
      nh      = nh_wide[HEAD_W-1:0];

      rd_req.en   = s1_go && upd;
      rd_req.addr = {slot, nh};

      issue.valid  = s1_valid_ff;
      issue.bank   = s1_bank_ff;
      issue.chan   = s1_chan_ff;
      issue.sample = s1_sample_ff;
      issue.upd    = upd;
      issue.addr   = {slot, nh};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_go && upd) begin
            head_ff[slot] <= nh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bank_ff   <= req_bank;
         s1_chan_ff   <= req_word[CHAN_LSB +: CHAN_W];
         s1_sample_ff <= req_word[SAMPLE_LSB +: SAMPLE_W];
      end
   end

   `MAWSUM_ASSERT(a_head_in_window, clock, reset, s1_go && upd |-> nh_wide < len_eff)

endmodule

>>> src/mawsum_accum.sv
// ---------------------------------------------------------------------------
// mawsum_accum
// Running sum update, ring write-back with forwarding, result register.
// ---------------------------------------------------------------------------
`include "multichannel_adc_window_sum_core_defines.svh"

module mawsum_accum (
   input  logic                               clock,
   input  logic                               reset,
   input  mawsum_pkg::issue_type              issue,
   output logic                               s2_ready,
   input  logic [mawsum_pkg::SAMPLE_W-1:0]    rd_data,
   output mawsum_pkg::ram_wr_type             wr_req,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_bank,
   output logic [mawsum_pkg::CHAN_W-1:0]      rsp_chan,
   output logic [mawsum_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic [mawsum_pkg::SUM_W-1:0]       rsp_sum,
   output logic                               rsp_sum_valid
);

   import mawsum_pkg::*;

   stage_type           s2_ff;
   stage_type           s2_in;
   logic                s2_valid_ff;
   logic                s2_valid_in;
   logic [SUM_W-1:0]    sum_ff [SLOT_COUNT];
   logic [SUM_W-1:0]    sum_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_bank_ff;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff;
   logic [SUM_W-1:0]    rsp_sum_ff;
   logic                rsp_sum_valid_ff;

   logic                out_en;
   logic                s2_go;
   logic                take;
   logic                fwd_hit;
   logic [SLOT_W-1:0]   s2_slot;
   logic [SAMPLE_W-1:0] old_sample;

   always_comb begin
      out_en   = !rsp_valid_ff || rsp_ready;
      s2_go    = s2_valid_ff && out_en;
      s2_ready = !s2_valid_ff || out_en;
      take     = issue.valid && s2_ready;

      s2_slot    = s2_ff.addr[ADDR_W-1 -: SLOT_W];
      // ring read raced a write to the same entry: use the written sample
      old_sample = s2_ff.fwd ? s2_ff.fwd_data : rd_data;
      sum_in     = sum_ff[s2_slot] - SUM_W'(old_sample) + SUM_W'(s2_ff.sample);

      wr_req.en   = s2_go && s2_ff.upd;
      wr_req.addr = s2_ff.addr;
      wr_req.data = s2_ff.sample;

      fwd_hit = wr_req.en && issue.upd && (issue.addr == s2_ff.addr);

      s2_in.bank     = issue.bank;
      s2_in.chan     = issue.chan;
      s2_in.sample   = issue.sample;
      s2_in.upd      = issue.upd;
      s2_in.addr     = issue.addr;
      s2_in.fwd      = fwd_hit;
      s2_in.fwd_data = s2_ff.sample;

      s2_valid_in  = take ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_req.en) begin
            sum_ff[s2_slot] <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s2_ff <= s2_in;
      end
      if (s2_go) begin
         rsp_bank_ff      <= s2_ff.bank;
         rsp_chan_ff      <= s2_ff.chan;
         rsp_sample_ff    <= s2_ff.sample;
         rsp_sum_ff       <= s2_ff.upd ? sum_in : '0;
         rsp_sum_valid_ff <= s2_ff.upd;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bank      = rsp_bank_ff;
   assign rsp_chan      = rsp_chan_ff;
   assign rsp_sample    = rsp_sample_ff;
   assign rsp_sum       = rsp_sum_ff;
   assign rsp_sum_valid = rsp_sum_valid_ff;

   `MAWSUM_ASSERT(a_idle_sum_zero, clock, reset, rsp_valid_ff && !rsp_sum_valid_ff |-> rsp_sum_ff == '0)
   `MAWSUM_ASSERT(a_fwd_needs_update, clock, reset, s2_valid_ff && s2_ff.fwd |-> s2_ff.upd)

endmodule

>>> src/multichannel_adc_window_sum_core.sv
// ---------------------------------------------------------------------------
// multichannel_adc_window_sum_core
// Per-channel moving sum over two banks of converter channels.
//
//   port group  dir  tdata / fields                    tuser
//   req_        in   [31:0] data_word                  [0] bank
//   rsp_        out  [2:0] out_channel, [12:3] latest  [0] out_bank
//                    _sample, [27:13] window_sum,
//                    [28] sum_valid, [31:29] zero
//   csr_        in   wen, addr (register index), wdata
//
// One transfer per cycle while rsp_ does not stall and no clear runs; results
// pass the input register (head/ring-read stage), sum stage, result register.
// After reset the sample ring memory is zeroed one entry a cycle, all
// RING_DEPTH (512) entries, with req_tready low; csr_ writes are taken.
// Backpressure on rsp_ stalls stage by stage; a new item is still taken
// while a result waits as long as a stage ahead has room.
// ---------------------------------------------------------------------------
`include "multichannel_adc_window_sum_core_defines.svh"

module multichannel_adc_window_sum_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mawsum_pkg::WORD_W-1:0]        req_tdata,   // [31:0] data_word
   input  logic                                 req_tuser,   // [0] bank
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mawsum_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // chan, sample, sum, sum_valid
   output logic                                 rsp_tuser,   // [0] out_bank
   input  logic                                 csr_wen,
   input  logic [mawsum_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mawsum_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import mawsum_pkg::*;

   logic [ENABLE_W-1:0]  enable_ff;
   logic [ENABLE_W-1:0]  enable_in;
   logic [LEN_REG_W-1:0] len0_ff;
   logic [LEN_REG_W-1:0] len0_in;
   logic [LEN_REG_W-1:0] len1_ff;
   logic [LEN_REG_W-1:0] len1_in;
   logic [ADDR_W:0]      clr_ff;
   logic [ADDR_W:0]      clr_in;

   logic                 clearing;
   ram_rd_type           rd_req;
   ram_wr_type           acc_wr;
   issue_type            issue;
   logic                 s2_ready;
   logic [SAMPLE_W-1:0]  rd_data;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [SAMPLE_W-1:0]  ram_wr_data;

   logic                 rsp_bank;
   logic [CHAN_W-1:0]    rsp_chan;
   logic [SAMPLE_W-1:0]  rsp_sample;
   logic [SUM_W-1:0]     rsp_sum;
   logic                 rsp_sum_valid;

   always_comb begin
      enable_in = enable_ff;
      len0_in   = len0_ff;
      len1_in   = len1_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_ENABLE:    enable_in = csr_wdata[ENABLE_W-1:0];
            CSR_LEN_BANK0: len0_in   = csr_wdata[LEN_REG_W-1:0];
            CSR_LEN_BANK1: len1_in   = csr_wdata[LEN_REG_W-1:0];
            default: ;
         endcase
      end

      clearing = !clr_ff[ADDR_W];
      clr_in   = clearing ? clr_ff + (ADDR_W+1)'(1) : clr_ff;

      if (clearing) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff[ADDR_W-1:0];
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = acc_wr.en;
         ram_wr_addr = acc_wr.addr;
         ram_wr_data = acc_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         len0_ff   <= '0;
         len1_ff   <= '0;
         clr_ff    <= '0;
      end else begin
         enable_ff <= enable_in;
         len0_ff   <= len0_in;
         len1_ff   <= len1_in;
         clr_ff    <= clr_in;
      end
   end

   mawsum_index u_index (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_bank    (req_tuser),
      .req_word    (req_tdata),
      .clearing    (clearing),
      .enable_mask (enable_ff[SLOT_COUNT-1:0]),
      .len_bank0   (len0_ff),
      .len_bank1   (len1_ff),
      .s2_ready    (s2_ready),
      .rd_req      (rd_req),
      .issue       (issue)
   );

   mawsum_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_data)
   );

   mawsum_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .issue         (issue),
      .s2_ready      (s2_ready),
      .rd_data       (rd_data),
      .wr_req        (acc_wr),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_bank      (rsp_bank),
      .rsp_chan      (rsp_chan),
      .rsp_sample    (rsp_sample),
      .rsp_sum       (rsp_sum),
      .rsp_sum_valid (rsp_sum_valid)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_sum_valid, rsp_sum, rsp_sample, rsp_chan};
   assign rsp_tuser = rsp_bank;

   `MAWSUM_ASSERT(a_no_item_write_in_clear, clock, reset, clearing |-> !acc_wr.en)
   `MAWSUM_ASSERT_NEXT(a_clear_done_stays, clock, reset, !clearing, !clearing)

endmodule
